// ----- design/longest_ideal_subsequence_core_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef LONGEST_IDEAL_SUBSEQUENCE_CORE_MACROS_SVH
`define LONGEST_IDEAL_SUBSEQUENCE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lis check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define LIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lis check failed: next-cycle implication");

`endif

// ----- design/lis_pkg.sv -----
// Shared types and constants for the longest ideal subsequence core.
// No dependencies; compiled first.
package lis_pkg;

  localparam int DEF_ALPHABET     = 26;
  localparam int DEF_LENGTH_WIDTH = 17;
  localparam int LETTER_W         = 5;
  localparam int WINDOW_W         = 5;
  localparam int OUT_W            = 17;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                first;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] best_length;
    logic [OUT_W-1:0] ending_here;
  } result_t;

  typedef logic [WINDOW_W-1:0] window_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MAX   = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // take the input word, clear on first
    logic load_peak;  // register the windowed maximum
    logic commit;     // write table, best and result register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // result register can take a word this cycle
  } dp_status_t;

endpackage

// ----- design/lis_chan_if.sv -----
// Valid/ready channel carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface lis_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/lis_ctrl.sv -----
// Controller: sequences accept, max search and table write for each word.
// Depends on lis_pkg.
module lis_ctrl import lis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_MAX: begin
        cmd.load_peak = 1'b1;
        state_next    = S_WRITE;
      end
      S_WRITE: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.accept = in_valid && in_ready;
    if (cmd.accept) begin
      state_next = S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/lis_datapath.sv -----
// Datapath: length table, windowed maximum tree, best tracker, result register.
// Depends on lis_pkg.
module lis_datapath import lis_pkg::*; #(
  parameter int ALPHABET     = DEF_ALPHABET,
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  output dp_status_t          status,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_first,
  input  logic                cfg_we,
  input  window_t             cfg_window,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [OUT_W-1:0]    out_best,
  output logic [OUT_W-1:0]    out_here
);

  // Letters above 2**LETTER_W-1 cannot arrive, so deeper entries would stay zero.
  localparam int Depth  = (ALPHABET < (1 << LETTER_W)) ? ALPHABET : (1 << LETTER_W);
  localparam int IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Leaves = 1 << IdxW;
  localparam int Nodes  = 2 * Leaves - 1;
  localparam logic [8:0] AlphaLimit = 9'(ALPHABET);

  typedef logic [LENGTH_WIDTH-1:0] len_t;

  len_t                len_table [Leaves];
  len_t                best;
  len_t                peak;
  window_t             window;
  logic [LETTER_W-1:0] letter_q;

  len_t                node [Nodes];
  logic                in_range;
  len_t                here;
  len_t                best_next;

  assign in_range = {4'b0, letter_q} < AlphaLimit;

  // Masked leaves, then a max tree from the bottom level up.
  always_comb begin
    logic [LETTER_W:0] lv;
    logic [LETTER_W:0] jv;
    logic [LETTER_W:0] gap;
    lv = {1'b0, letter_q};
    for (int j = 0; j < Leaves; j++) begin
      jv  = (LETTER_W + 1)'(j);
      gap = (lv >= jv) ? (lv - jv) : (jv - lv);
      node[Leaves - 1 + j] = (gap <= {1'b0, window}) ? len_table[j] : '0;
    end
    for (int i = Leaves - 2; i >= 0; i--) begin
      node[i] = (node[2*i+1] >= node[2*i+2]) ? node[2*i+1] : node[2*i+2];
    end
  end

  always_comb begin
    if (!in_range) begin
      here = '0;
    end else if (peak == '1) begin
      here = peak;  // saturate
    end else begin
      here = peak + LENGTH_WIDTH'(1);
    end
    best_next = (here > best) ? here : best;
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (cfg_we) begin
      window <= cfg_window;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      letter_q <= in_letter;
    end
    if (cmd.load_peak) begin
      peak <= node[0];
    end
  end

  // A clear on a new string overrides the write of the word just finishing.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < Leaves; j++) begin
        len_table[j] <= '0;
      end
      best <= '0;
    end else if (cmd.accept && in_first) begin
      for (int j = 0; j < Leaves; j++) begin
        len_table[j] <= '0;
      end
      best <= '0;
    end else if (cmd.commit) begin
      if (in_range) begin
        len_table[letter_q[IdxW-1:0]] <= here;
      end
      best <= best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_best <= OUT_W'(best_next);
      out_here <= OUT_W'(here);
    end
  end

endmodule

// ----- design/longest_ideal_subsequence_core.sv -----
// Top level of the longest ideal subsequence core: controller plus datapath.
// Depends on lis_pkg, lis_chan_if, lis_ctrl and lis_datapath.
//
//   channel   role   payload                     handshake
//   items     sink   letter[4:0], first          valid/ready
//   results   source best_length, ending_here    valid/ready
//   cfg       sink   window[4:0]                 valid/ready, always ready
//
// Each word passes a max state, which registers the windowed max over the length table,
// then a write state, which writes the letter's entry; the next word needs that write.
// The result register lets a new word in while the last result waits.
// A stalled result holds the write cycle, so the next word waits with it.
// Reset clears table, best, window and state at once; no clearing pass.
module longest_ideal_subsequence_core import lis_pkg::*; #(
  parameter int ALPHABET     = DEF_ALPHABET,
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input logic        clk,
  input logic        rst,
  lis_chan_if.sink   items,
  lis_chan_if.source results,
  lis_chan_if.sink   cfg
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  item_t      item;
  window_t    cfg_window;

  assign item       = items.payload;
  assign cfg_window = cfg.payload;
  assign cfg.ready  = 1'b1;

  lis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lis_datapath #(
    .ALPHABET     (ALPHABET),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_letter  (item.letter),
    .in_first   (item.first),
    .cfg_we     (cfg.valid),
    .cfg_window (cfg_window),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .out_best   (results.payload.best_length),
    .out_here   (results.payload.ending_here)
  );

endmodule

// ----- design/lis_checker.sv -----
// Port-level checker for longest_ideal_subsequence_core, bound to the top level.
// Depends on lis_pkg and longest_ideal_subsequence_core_macros.svh.
`include "longest_ideal_subsequence_core_macros.svh"

module lis_checker import lis_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_payload
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // the max search cycle never takes a word
  `LIS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)

  // a fresh result rises once its word has passed the max search and write states
  `LIS_ASSERT_SAME(a_result_from_word, $rose(out_valid), $past(in_acc, 3))

  // a stalled result holds
  `LIS_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
                   out_valid && $stable(out_payload))

endmodule

bind longest_ideal_subsequence_core lis_checker u_lis_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_payload (results.payload)
);
